>>> rtl/frustum_box_cull_core_defines.svh
// Assertion macros shared by the frustum box cull RTL.
// No dependencies; files that check their own logic include this header.
`ifndef FRUSTUM_BOX_CULL_CORE_DEFINES_SVH
`define FRUSTUM_BOX_CULL_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication check, off during reset
`define FBC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fbc check failed");
// Next-cycle implication check, off during reset
`define FBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fbc check failed");
`else
`define FBC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define FBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/fbc_pkg.sv
// Types, codes and constants of the frustum box cull block.
// No dependencies; used by every module of the block.
package fbc_pkg;

	localparam int FRAC_W     = 16;
	localparam int MAT_DEPTH  = 16;
	localparam int MAT_AW     = 4;
	localparam int COL_W      = 2;
	localparam int ROW_W      = 2;
	localparam int PLANE_W    = 3;
	localparam int DRAIN_W    = 2;
	localparam int VERDICT_W  = 2;

	// Request codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TEST = 1'b1;

	// Verdict codes
	localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE   = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_INTERSECT = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_INSIDE    = 2'd2;

	// Matrix columns: x, y, z normal terms and the constant term
	localparam logic [COL_W-1:0] COL_X = 2'd0;
	localparam logic [COL_W-1:0] COL_Y = 2'd1;
	localparam logic [COL_W-1:0] COL_Z = 2'd2;
	localparam logic [COL_W-1:0] COL_D = 2'd3;

	// Fourth matrix row, common to every plane
	localparam logic [ROW_W-1:0] ROW_W_TERM = 2'd3;

	localparam logic [PLANE_W-1:0] PLANE_LAST = 3'd5;
	localparam logic [DRAIN_W-1:0] DRAIN_LAST = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_TEST,
		ST_DRAIN,
		ST_RESULT
	} fbc_state_t;

	// One step of the shared multiply-accumulate unit
	typedef struct packed {
		logic             vld;
		logic             clr;
		logic             first;
		logic             last;
		logic             sub;
		logic [COL_W-1:0] col;
	} fbc_step_t;

	// Sticky sign flags over all planes of one test
	typedef struct packed {
		logic neg_p;
		logic neg_n;
	} fbc_flags_t;

	// Planes 0,2,5 subtract their source row from the fourth row, the others add it
	function automatic logic plane_is_sub(input logic [PLANE_W-1:0] plane);
		logic r;
		case (plane)
			3'd0: r = 1'b1;
			3'd2: r = 1'b1;
			3'd5: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// Source row of a plane: two planes per row
	function automatic logic [ROW_W-1:0] plane_src_row(input logic [PLANE_W-1:0] plane);
		return plane[PLANE_W-1:1];
	endfunction

endpackage

>>> rtl/fbc_mat_mem.sv
// View-projection matrix store: 16 entries, one write and two registered reads.
// Depends on fbc_pkg. Entries never written read as zero through valid bits.
module fbc_mat_mem #(
	parameter int COORD_W = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [fbc_pkg::MAT_AW-1:0]     wr_addr,
	input  logic signed [COORD_W-1:0]      wr_data,
	input  logic [fbc_pkg::MAT_AW-1:0]     rd_addr_a,
	input  logic [fbc_pkg::MAT_AW-1:0]     rd_addr_b,
	output logic signed [COORD_W-1:0]      rd_a,
	output logic signed [COORD_W-1:0]      rd_b
);
	import fbc_pkg::*;

	logic signed [COORD_W-1:0] mem_q [MAT_DEPTH];
	logic [MAT_DEPTH-1:0]      ent_vld_q;
	logic signed [COORD_W-1:0] rd_a_q;
	logic signed [COORD_W-1:0] rd_b_q;
	logic                      rd_a_vld_q;
	logic                      rd_b_vld_q;

	// Write port and registered read data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_a_q <= mem_q[rd_addr_a];
		rd_b_q <= mem_q[rd_addr_b];
	end

	// Track written entries; reset makes the whole store read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q  <= '0;
			rd_a_vld_q <= 1'b0;
			rd_b_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				ent_vld_q[wr_addr] <= 1'b1;
			end
			rd_a_vld_q <= ent_vld_q[rd_addr_a];
			rd_b_vld_q <= ent_vld_q[rd_addr_b];
		end
	end

	// Mask entries not yet written
	assign rd_a = rd_a_vld_q ? rd_a_q : '0;
	assign rd_b = rd_b_vld_q ? rd_b_q : '0;

endmodule

>>> rtl/fbc_mac.sv
// Shared plane unit: builds one plane coefficient a step, multiplies it by the
// positive and negative vertex coordinates and accumulates both distances.
// Depends on fbc_pkg. Three stages after the matrix read.
module fbc_mac #(
	parameter int COORD_W = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fbc_pkg::fbc_step_t        step_s0,
	input  logic signed [COORD_W-1:0] rd_a,
	input  logic signed [COORD_W-1:0] rd_b,
	input  logic signed [COORD_W-1:0] bmin [3],
	input  logic signed [COORD_W-1:0] bmax [3],
	output fbc_pkg::fbc_flags_t       flags
);
	import fbc_pkg::*;

	localparam int COEF_W = COORD_W + 1;
	localparam int PROD_W = 2 * COORD_W + 1;
	localparam int ACC_W  = 2 * COORD_W + 3;

	fbc_step_t                step_s1;
	fbc_step_t                step_s2;
	fbc_step_t                step_s3;
	logic signed [COEF_W-1:0] coef;
	logic signed [COEF_W-1:0] coef_s2;
	logic signed [COORD_W-1:0] sel_max;
	logic signed [COORD_W-1:0] sel_min;
	logic signed [COORD_W-1:0] cp;
	logic signed [COORD_W-1:0] cn;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [PROD_W-1:0] mul_n;
	logic signed [PROD_W-1:0] prod_p_s3;
	logic signed [PROD_W-1:0] prod_n_s3;
	logic signed [ACC_W-1:0]  acc_p_q;
	logic signed [ACC_W-1:0]  acc_n_q;
	logic signed [ACC_W-1:0]  sum_p;
	logic signed [ACC_W-1:0]  sum_n;
	fbc_flags_t               flags_q;
	fbc_flags_t               flags_base;

	// Step control travels alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1 <= '0;
			step_s2 <= '0;
			step_s3 <= '0;
		end else begin
			step_s1 <= step_s0;
			step_s2 <= step_s1;
			step_s3 <= step_s2;
		end
	end

	// Stage 1: plane coefficient from the fourth row and the source row
	assign coef = step_s1.sub ? (COEF_W'(rd_a) - COEF_W'(rd_b))
	                          : (COEF_W'(rd_a) + COEF_W'(rd_b));

	always_ff @(posedge clk) begin
		coef_s2 <= coef;
	end

	// Stage 2: pick the box corners for this axis
	always_comb begin
		case (step_s2.col)
			COL_X: begin
				sel_max = bmax[0];
				sel_min = bmin[0];
			end
			COL_Y: begin
				sel_max = bmax[1];
				sel_min = bmin[1];
			end
			COL_Z: begin
				sel_max = bmax[2];
				sel_min = bmin[2];
			end
			default: begin
				sel_max = '0;
				sel_min = '0;
			end
		endcase
	end

	// Positive vertex takes the max corner where the coefficient is not negative
	assign cp = coef_s2[COEF_W-1] ? sel_min : sel_max;
	assign cn = coef_s2[COEF_W-1] ? sel_max : sel_min;

	assign mul_p = PROD_W'(coef_s2) * PROD_W'(cp);
	assign mul_n = PROD_W'(coef_s2) * PROD_W'(cn);

	// Constant term is scaled up to the product's fraction
	always_ff @(posedge clk) begin
		if (step_s2.col == COL_D) begin
			prod_p_s3 <= PROD_W'(coef_s2) <<< FRAC_W;
			prod_n_s3 <= PROD_W'(coef_s2) <<< FRAC_W;
		end else begin
			prod_p_s3 <= mul_p;
			prod_n_s3 <= mul_n;
		end
	end

	// Stage 3: accumulate both distances of the plane
	assign sum_p = (step_s3.first ? ACC_W'(0) : acc_p_q) + ACC_W'(prod_p_s3);
	assign sum_n = (step_s3.first ? ACC_W'(0) : acc_n_q) + ACC_W'(prod_n_s3);

	always_ff @(posedge clk) begin
		if (step_s3.vld) begin
			acc_p_q <= sum_p;
			acc_n_q <= sum_n;
		end
	end

	// Collect negative distances at the end of each plane; clear at a new test
	assign flags_base = step_s3.clr ? '0 : flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (step_s3.vld) begin
			flags_q.neg_p <= flags_base.neg_p | (step_s3.last & sum_p[ACC_W-1]);
			flags_q.neg_n <= flags_base.neg_n | (step_s3.last & sum_n[ACC_W-1]);
		end
	end

	assign flags = flags_q;

endmodule

>>> rtl/fbc_ctrl.sv
// Sequencer of the frustum box cull block: row loads, plane steps, result register.
// Depends on fbc_pkg and frustum_box_cull_core_defines.svh.
`include "frustum_box_cull_core_defines.svh"
module fbc_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             req_type,
	input  logic [fbc_pkg::ROW_W-1:0]        row_idx,
	input  fbc_pkg::fbc_flags_t              flags,
	output fbc_pkg::fbc_step_t               step_s0,
	output logic [fbc_pkg::MAT_AW-1:0]       rd_addr_a,
	output logic [fbc_pkg::MAT_AW-1:0]       rd_addr_b,
	output logic                             wr_en,
	output logic [fbc_pkg::MAT_AW-1:0]       wr_addr,
	output logic [fbc_pkg::COL_W-1:0]        wr_col,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [fbc_pkg::VERDICT_W-1:0]    verdict
);
	import fbc_pkg::*;

	fbc_state_t             state_q;
	fbc_state_t             state_d;
	logic [COL_W-1:0]       col_q;
	logic [PLANE_W-1:0]     plane_q;
	logic [DRAIN_W-1:0]     drain_q;
	logic                   out_valid_q;
	logic [VERDICT_W-1:0]   verdict_q;
	logic                   result_load;
	logic [VERDICT_W-1:0]   verdict_d;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (req_type == REQ_LOAD) ? ST_LOAD : ST_TEST;
				end
			end
			ST_LOAD: begin
				if (col_q == COL_D) begin
					state_d = ST_IDLE;
				end
			end
			ST_TEST: begin
				if (col_q == COL_D && plane_q == PLANE_LAST) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q == DRAIN_LAST) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance column, plane and drain counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			plane_q <= '0;
			drain_q <= '0;
		end else begin
			if (state_q == ST_LOAD || state_q == ST_TEST) begin
				col_q <= col_q + 1'b1;
			end else begin
				col_q <= '0;
			end
			if (state_q == ST_TEST) begin
				if (col_q == COL_D) begin
					plane_q <= plane_q + 1'b1;
				end
			end else begin
				plane_q <= '0;
			end
			if (state_q == ST_DRAIN) begin
				drain_q <= drain_q + 1'b1;
			end else begin
				drain_q <= '0;
			end
		end
	end

	// Outputs per state
	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		wr_en         = (state_q == ST_LOAD);
		wr_col        = col_q;
		wr_addr       = {row_idx, col_q};
		step_s0.vld   = (state_q == ST_TEST);
		step_s0.clr   = (plane_q == '0) && (col_q == COL_X);
		step_s0.first = (col_q == COL_X);
		step_s0.last  = (col_q == COL_D);
		step_s0.sub   = plane_is_sub(plane_q);
		step_s0.col   = col_q;
		rd_addr_a     = {ROW_W_TERM, col_q};
		rd_addr_b     = {plane_src_row(plane_q), col_q};
		result_load   = (state_q == ST_RESULT) && (!out_valid_q || out_ready);
	end

	// Outside beats intersecting beats inside
	assign verdict_d = flags.neg_p ? VERDICT_OUTSIDE :
	                   flags.neg_n ? VERDICT_INTERSECT : VERDICT_INSIDE;

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			verdict_q <= verdict_d;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

	`FBC_ASSERT_SAME(a_verdict_code, clk, arst_n, out_valid_q, verdict_q != 2'd3)
	`FBC_ASSERT_SAME(a_plane_range, clk, arst_n, state_q == ST_TEST, plane_q <= PLANE_LAST)
	`FBC_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && in_ready, (state_q == ST_LOAD || state_q == ST_TEST))

endmodule

>>> rtl/frustum_box_cull_core.sv
// Frustum box cull core: top level of the block.
// Depends on fbc_pkg, fbc_mat_mem, fbc_mac and fbc_ctrl.
//
// Usage:
// - Input channel (in_valid/in_ready) takes one transaction at a time. req_type
//   REQ_LOAD writes row row_index of the 4x4 view-projection matrix from
//   row_col_0..row_col_3; REQ_TEST classifies the box box_min_*/box_max_*.
// - A load gives no result and occupies the block from acceptance to the next
//   possible acceptance (one matrix entry written per cycle).
// - A test gives one verdict on the output channel (out_valid/out_ready):
//   0 outside, 1 intersecting, 2 inside. The shared multiply-accumulate unit
//   takes one matrix column of one plane per cycle, 24 steps over six planes,
//   then the pipeline drains and the result register is loaded; out_valid
//   rises in the same cycle that the next transaction can be accepted.
// - A verdict waits in the output register while out_ready is low. A new
//   transaction is still accepted; a finishing test holds until the register
//   is free.
// - Reset (arst_n low) clears the matrix to zero and drops any pending result.
module frustum_box_cull_core #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             req_type,
	input  logic [1:0]                       row_index,
	input  logic signed [31:0]               row_col_0,
	input  logic signed [31:0]               row_col_1,
	input  logic signed [31:0]               row_col_2,
	input  logic signed [31:0]               row_col_3,
	input  logic signed [31:0]               box_min_x,
	input  logic signed [31:0]               box_min_y,
	input  logic signed [31:0]               box_min_z,
	input  logic signed [31:0]               box_max_x,
	input  logic signed [31:0]               box_max_y,
	input  logic signed [31:0]               box_max_z,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [fbc_pkg::VERDICT_W-1:0]    verdict
);
	import fbc_pkg::*;

	// Coordinates never exceed the 32-bit fields
	localparam int CW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

	logic                  req_type_q;
	logic [ROW_W-1:0]      row_idx_q;
	logic signed [CW-1:0]  row_q [4];
	logic signed [CW-1:0]  bmin_q [3];
	logic signed [CW-1:0]  bmax_q [3];
	logic                  accept;
	fbc_step_t             step_s0;
	fbc_flags_t            flags;
	logic [MAT_AW-1:0]     rd_addr_a;
	logic [MAT_AW-1:0]     rd_addr_b;
	logic                  wr_en;
	logic [MAT_AW-1:0]     wr_addr;
	logic [COL_W-1:0]      wr_col;
	logic signed [CW-1:0]  rd_a;
	logic signed [CW-1:0]  rd_b;

	assign accept = in_valid && in_ready;

	// Capture the transaction; low bits only, taken as signed CW-bit values
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req_type;
			row_idx_q  <= row_index;
			row_q[0]   <= row_col_0[CW-1:0];
			row_q[1]   <= row_col_1[CW-1:0];
			row_q[2]   <= row_col_2[CW-1:0];
			row_q[3]   <= row_col_3[CW-1:0];
			bmin_q[0]  <= box_min_x[CW-1:0];
			bmin_q[1]  <= box_min_y[CW-1:0];
			bmin_q[2]  <= box_min_z[CW-1:0];
			bmax_q[0]  <= box_max_x[CW-1:0];
			bmax_q[1]  <= box_max_y[CW-1:0];
			bmax_q[2]  <= box_max_z[CW-1:0];
		end
	end

	fbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.row_idx   (row_idx_q),
		.flags     (flags),
		.step_s0   (step_s0),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_col    (wr_col),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.verdict   (verdict)
	);

	fbc_mat_mem #(
		.COORD_W (CW)
	) u_mat_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en && (req_type_q == REQ_LOAD)),
		.wr_addr   (wr_addr),
		.wr_data   (row_q[wr_col]),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_a      (rd_a),
		.rd_b      (rd_b)
	);

	fbc_mac #(
		.COORD_W (CW)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_s0 (step_s0),
		.rd_a    (rd_a),
		.rd_b    (rd_b),
		.bmin    (bmin_q),
		.bmax    (bmax_q),
		.flags   (flags)
	);

endmodule

>>> sim/tb_frustum_box_cull_core.sv
// Testbench for frustum_box_cull_core: loads view-projection rows, sends boxes and checks
// each verdict against a cycle-free predictor of the plane distance tests.
// Depends on fbc_pkg and the frustum_box_cull_core RTL.
module tb_frustum_box_cull_core;
	timeunit 1ns;
	timeprecision 1ps;

	import fbc_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 1250;
	localparam int DRAIN_CYCLES = 40;

	// Planes 0, 2 and 5 subtract their source row from the w row
	localparam logic [5:0] PLANE_SUBTRACTS = 6'b100101;

	localparam logic [31:0] Q_MIN = 32'h8000_0000;
	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_ONE = 32'h0001_0000;
	localparam logic [31:0] Q_ULP = 32'h0000_0001;

	typedef struct packed {
		logic             req;
		logic [1:0]       row;
		logic [3:0][31:0] cols;
		logic [2:0][31:0] lo;
		logic [2:0][31:0] hi;
	} cull_req_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 req_type;
	logic [1:0]           row_index;
	logic signed [31:0]   row_col_0;
	logic signed [31:0]   row_col_1;
	logic signed [31:0]   row_col_2;
	logic signed [31:0]   row_col_3;
	logic signed [31:0]   box_min_x;
	logic signed [31:0]   box_min_y;
	logic signed [31:0]   box_min_z;
	logic signed [31:0]   box_max_x;
	logic signed [31:0]   box_max_y;
	logic signed [31:0]   box_max_z;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [VERDICT_W-1:0] verdict;

	// Predictor state: shadow of the matrix store and verdicts still in flight
	logic [31:0]          view_proj [16];
	logic [VERDICT_W-1:0] verdicts_due [$];
	logic [VERDICT_W-1:0] want_verdict;

	int          mismatch_count = 0;
	int          items_sent     = 0;
	int          cycle_count    = 0;
	int          stall_level    = 0;
	bit          gaps_on        = 1'b0;
	int          burst_left     = 4;
	int          ready_phase    = 0;
	logic [31:0] ready_mask     = '1;

	frustum_box_cull_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.row_index (row_index),
		.row_col_0 (row_col_0),
		.row_col_1 (row_col_1),
		.row_col_2 (row_col_2),
		.row_col_3 (row_col_3),
		.box_min_x (box_min_x),
		.box_min_y (box_min_y),
		.box_min_z (box_min_z),
		.box_max_x (box_max_x),
		.box_max_y (box_max_y),
		.box_max_z (box_max_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.verdict   (verdict)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Classify a box against the six planes built from the shadow matrix
	function automatic logic [VERDICT_W-1:0] classify_box(input logic [2:0][31:0] lo,
			input logic [2:0][31:0] hi);
		logic signed [32:0]   coef [4];
		logic signed [31:0]   w_term, src_term, far_c, near_c;
		logic signed [79:0]   far_dist, near_dist, c_w;
		logic [VERDICT_W-1:0] result;
		logic                 done;
		int                   pl, k, src;
		result = VERDICT_INSIDE;
		done = 1'b0;
		for (pl = 0; pl < 6; pl++) begin
			if (!done) begin
				src = pl / 2;
				for (k = 0; k < 4; k++) begin
					w_term = view_proj[12 + k];
					src_term = view_proj[src * 4 + k];
					coef[k] = PLANE_SUBTRACTS[pl] ? w_term - src_term : w_term + src_term;
				end
				// Constant term sits at the Q32.32 product scale
				c_w = coef[3];
				far_dist = c_w * 80'sd65536;
				near_dist = far_dist;
				for (k = 0; k < 3; k++) begin
					if (coef[k] >= 0) begin
						far_c = hi[k];
						near_c = lo[k];
					end else begin
						far_c = lo[k];
						near_c = hi[k];
					end
					c_w = coef[k];
					far_dist = far_dist + c_w * far_c;
					near_dist = near_dist + c_w * near_c;
				end
				if (far_dist < 0) begin
					result = VERDICT_OUTSIDE;
					done = 1'b1;
				end else if (near_dist < 0) begin
					result = VERDICT_INTERSECT;
				end
			end
		end
		return result;
	endfunction

	function automatic logic [2:0][31:0] xyz(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		return {z, y, x};
	endfunction

	function automatic logic [31:0] to_q16(input longint v);
		if (v > 64'sd2147483647)
			return Q_MAX;
		if (v < -64'sd2147483648)
			return Q_MIN;
		return v[31:0];
	endfunction

	// Row load; box fields carry noise since the block ignores them
	function automatic cull_req_t load_row(input logic [1:0] row, input logic [31:0] c0,
			input logic [31:0] c1, input logic [31:0] c2, input logic [31:0] c3);
		cull_req_t rq;
		rq.req = REQ_LOAD;
		rq.row = row;
		rq.cols = {c3, c2, c1, c0};
		rq.lo = xyz($urandom, $urandom, $urandom);
		rq.hi = xyz($urandom, $urandom, $urandom);
		return rq;
	endfunction

	// Box test; row fields carry noise since the block ignores them
	function automatic cull_req_t box_test(input logic [2:0][31:0] lo,
			input logic [2:0][31:0] hi);
		cull_req_t rq;
		rq.req = REQ_TEST;
		rq.row = 2'($urandom_range(0, 3));
		rq.cols = {$urandom, $urandom, $urandom, $urandom};
		rq.lo = lo;
		rq.hi = hi;
		return rq;
	endfunction

	// Drive one transaction, wait for acceptance, update the predictor, then maybe idle
	task automatic send_request(input cull_req_t rq);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= rq.req;
		row_index <= rq.row;
		row_col_0 <= rq.cols[0];
		row_col_1 <= rq.cols[1];
		row_col_2 <= rq.cols[2];
		row_col_3 <= rq.cols[3];
		box_min_x <= rq.lo[0];
		box_min_y <= rq.lo[1];
		box_min_z <= rq.lo[2];
		box_max_x <= rq.hi[0];
		box_max_y <= rq.hi[1];
		box_max_z <= rq.hi[2];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (rq.req == REQ_LOAD) begin
			for (int k = 0; k < 4; k++)
				view_proj[rq.row * 4 + k] = rq.cols[k];
		end else begin
			verdicts_due.push_back(classify_box(rq.lo, rq.hi));
		end
		items_sent++;
		// End a burst with a random gap
		burst_left--;
		if (gaps_on && burst_left <= 0) begin
			burst_left = $urandom_range(1, 8);
			gap = $urandom_range(1, 6);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	// Receiver stalls: a fresh 32-bit ready pattern, denser stalls at higher levels
	always @(negedge clk) begin
		if (ready_phase == 0) begin
			case (stall_level)
				1: ready_mask = $urandom | $urandom;
				2: ready_mask = $urandom;
				3: ready_mask = $urandom & $urandom;
				default: ready_mask = '1;
			endcase
		end
		out_ready <= (stall_level == 0) || ready_mask[ready_phase];
		ready_phase = (ready_phase + 1) % 32;
	end

	// Check each verdict transaction against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (verdicts_due.size() == 0) begin
				$display("%0t: unexpected verdict, expected none, actual %0d", $time, verdict);
				mismatch_count++;
			end else begin
				want_verdict = verdicts_due.pop_front();
				if (verdict !== want_verdict) begin
					$display("%0t: verdict mismatch, expected %0d, actual %0d",
						$time, want_verdict, verdict);
					mismatch_count++;
				end
			end
		end
	end

	// Cleared matrix: every plane is zero, so any box is inside
	task automatic test_cleared_matrix();
		send_request(box_test(xyz(Q_MIN, Q_MIN, Q_MIN), xyz(Q_MAX, Q_MAX, Q_MAX)));
		send_request(box_test(xyz($urandom, $urandom, $urandom),
			xyz($urandom, $urandom, $urandom)));
	endtask

	// Full-scale matrix entries against full-scale boxes
	task automatic test_extreme_entries();
		send_request(load_row(2'd0, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
		send_request(load_row(2'd1, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
		send_request(load_row(2'd2, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
		send_request(load_row(ROW_W_TERM, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
		send_request(box_test(xyz(Q_MIN, Q_MIN, Q_MIN), xyz(Q_MAX, Q_MAX, Q_MAX)));
		send_request(box_test(xyz('0, '0, '0), xyz('0, '0, '0)));
		send_request(box_test(xyz(Q_MAX, Q_MAX, Q_MAX), xyz(Q_MIN, Q_MIN, Q_MIN)));
		send_request(box_test(xyz('1, '1, '1), xyz(Q_ULP, Q_ULP, Q_ULP)));
		send_request(load_row(ROW_W_TERM, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
		send_request(box_test(xyz(Q_MIN, Q_MIN, Q_MIN), xyz(Q_MAX, Q_MAX, Q_MAX)));
	endtask

	// Unit cube frustum: faces on the planes give zero distance, one ulp out does not
	task automatic test_exact_boundary();
		logic [31:0] neg_one;
		neg_one = -Q_ONE;
		send_request(load_row(2'd0, Q_ONE, '0, '0, '0));
		send_request(load_row(2'd1, '0, Q_ONE, '0, '0));
		send_request(load_row(2'd2, '0, '0, Q_ONE, '0));
		send_request(load_row(ROW_W_TERM, '0, '0, '0, Q_ONE));
		send_request(box_test(xyz(neg_one, neg_one, neg_one), xyz(Q_ONE, Q_ONE, Q_ONE)));
		send_request(box_test(xyz(neg_one, neg_one, neg_one),
			xyz(Q_ONE + Q_ULP, Q_ONE, Q_ONE)));
		send_request(box_test(xyz(Q_ONE + Q_ULP, '0, '0), xyz(Q_ONE + Q_ONE, '0, '0)));
		send_request(box_test(xyz(Q_ONE, Q_ONE, Q_ONE), xyz(Q_ONE, Q_ONE, Q_ONE)));
		send_request(box_test(xyz('0, '0, '0), xyz('0, '0, '0)));
	endtask

	// Corners used as given when min exceeds max
	task automatic test_inverted_boxes();
		send_request(box_test(xyz(Q_ONE, Q_ONE, Q_ONE), xyz(-Q_ONE, -Q_ONE, -Q_ONE)));
		send_request(box_test(xyz(Q_ONE + Q_ONE, '0, '0), xyz(-(Q_ONE + Q_ONE), '0, '0)));
	endtask

	// Random scenes: load a matrix, then send boxes framed around its frustum
	task automatic test_random_scenes(input int item_budget);
		logic [3:0][31:0] rows [4];
		logic [2:0][31:0] lo, hi;
		longint           span [3];
		longint           c, hs, a, b;
		int               goal, mode, kind, r, k, w, s, rot, skip, n_tests;
		goal = items_sent + item_budget;
		while (items_sent < goal) begin
			stall_level = $urandom_range(0, 3);
			gaps_on = ($urandom_range(0, 3) != 0);
			mode = $urandom_range(0, 9);
			// Build the matrix: orthographic-like, small random, or full range
			if (mode < 6) begin
				w = $urandom_range(1 << 15, 1 << 20);
				for (r = 0; r < 4; r++)
					rows[r] = '0;
				rows[3][3] = w;
				for (k = 0; k < 3; k++) begin
					s = $urandom_range(1 << 14, 1 << 17);
					span[k] = (longint'(w) <<< 16) / s;
					if ($urandom_range(0, 3) == 0)
						s = -s;
					rows[k][k] = s;
				end
				if ($urandom_range(0, 1) == 1) begin
					for (r = 0; r < 4; r++)
						for (k = 0; k < 4; k++)
							if ($urandom_range(0, 3) == 0)
								rows[r][k] = rows[r][k] + 32'($urandom_range(0, 2048)) - 32'd1024;
				end
			end else if (mode < 8) begin
				for (r = 0; r < 4; r++)
					for (k = 0; k < 4; k++)
						rows[r][k] = 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
				rows[3][3] = $urandom_range(1 << 16, 1 << 22);
				for (k = 0; k < 3; k++)
					span[k] = longint'(1) <<< $urandom_range(10, 22);
			end else begin
				for (r = 0; r < 4; r++)
					rows[r] = {$urandom, $urandom, $urandom, $urandom};
				for (k = 0; k < 3; k++)
					span[k] = longint'(1) <<< $urandom_range(4, 29);
			end
			// Load the rows in rotated order, now and then keeping an old row
			rot = $urandom_range(0, 3);
			skip = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4;
			for (r = 0; r < 4; r++)
				if (((r + rot) % 4) != skip)
					send_request(load_row(2'((r + rot) % 4), rows[(r + rot) % 4][0],
						rows[(r + rot) % 4][1], rows[(r + rot) % 4][2], rows[(r + rot) % 4][3]));
			n_tests = $urandom_range(4, 25);
			repeat (n_tests) begin
				kind = $urandom_range(0, 19);
				if (kind < 15) begin
					for (k = 0; k < 3; k++) begin
						c = longint'($urandom_range(0, 32'(4 * span[k]))) - 2 * span[k];
						hs = $urandom_range(0, 32'(span[k]));
						a = c - hs;
						b = c + hs;
						if ($urandom_range(0, 9) == 0)
							b = span[k];
						if ($urandom_range(0, 9) == 0)
							a = -span[k];
						lo[k] = to_q16((kind == 14) ? b : a);
						hi[k] = to_q16((kind == 14) ? a : b);
					end
				end else if (kind < 18) begin
					lo = xyz($urandom, $urandom, $urandom);
					hi = xyz($urandom, $urandom, $urandom);
				end else begin
					for (k = 0; k < 3; k++)
						lo[k] = to_q16(longint'($urandom_range(0, 32'(2 * span[k]))) - span[k]);
					hi = lo;
				end
				send_request(box_test(lo, hi));
				// Occasionally overwrite a row between boxes
				if ($urandom_range(0, 29) == 0)
					send_request(load_row(2'($urandom_range(0, 3)), $urandom, $urandom,
						$urandom, $urandom));
			end
		end
	endtask

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_LOAD;
		row_index = '0;
		row_col_0 = '0;
		row_col_1 = '0;
		row_col_2 = '0;
		row_col_3 = '0;
		box_min_x = '0;
		box_min_y = '0;
		box_min_z = '0;
		box_max_x = '0;
		box_max_y = '0;
		box_max_z = '0;
		for (int i = 0; i < 16; i++)
			view_proj[i] = '0;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_cleared_matrix();
		test_extreme_entries();
		test_exact_boundary();
		test_inverted_boxes();
		test_random_scenes(RANDOM_ITEMS);

		// Drain outstanding verdicts, then let any trailing load finish
		@(negedge clk);
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/fbc_pkg.sv
rtl/fbc_mat_mem.sv
rtl/fbc_mac.sv
rtl/fbc_ctrl.sv
rtl/frustum_box_cull_core.sv
sim/tb_frustum_box_cull_core.sv
